// ===== rtl/core/rpd_pkg.sv =====
// ----------------------------------------------------------------------------
// rpd_pkg: shared types and codes of the rssi proximity detector
// register indexes, packet kinds, report kinds and channel widths
// ----------------------------------------------------------------------------
package rpd_pkg;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;
    localparam int IN_DATA_W  = 64;
    localparam int OUT_DATA_W = 32;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_RSSI_THRESHOLD  = 3'd0,
        CFG_CONTACT_SECONDS = 3'd1,
        CFG_ABSENT_SECONDS  = 3'd2,
        CFG_DETECT_INTERVAL = 3'd3,
        CFG_ABSENT_INTERVAL = 3'd4,
        CFG_OWN_DEVICE_TYPE = 3'd5
    } t_cfg_idx;

    // packet kinds on s_axis_tuser
    localparam logic OP_BEACON = 1'b0;
    localparam logic OP_SENSOR = 1'b1;

    // report kinds on m_axis_tuser
    localparam logic EV_DETECT = 1'b0;
    localparam logic EV_ABSENT = 1'b1;

    // one packet event as it moves down the pipeline
    typedef struct packed {
        logic              op;
        logic              peer_type;
        logic signed [7:0] rssi;
        logic [31:0]       tick;
        logic [15:0]       source_id;
    } t_event;

endpackage

// ===== rtl/core/rpd_sec_div.sv =====
// ----------------------------------------------------------------------------
// rpd_sec_div: tick to seconds converter
// three stage divide by a constant: reciprocal multiply, back multiply,
// one step correction; keeps the low 16 bits of the quotient
// ----------------------------------------------------------------------------
module rpd_sec_div #(
    parameter int TICKS_PER_SECOND = 65536
) (
    input  logic        i_clk,
    input  logic        i_en,
    input  logic [31:0] i_tick,
    output logic [15:0] o_sec
);

    localparam int          L        = $clog2(TICKS_PER_SECOND);
    localparam int          SH       = 31 + L;
    localparam logic [63:0] RECIP64  = (64'd1 << SH) / TICKS_PER_SECOND;
    localparam logic [31:0] RECIP    = RECIP64[31:0];
    localparam logic [31:0] TPS      = 32'(TICKS_PER_SECOND);

    logic [63:0] r_prod;
    logic [31:0] r_x1;
    logic [31:0] r_qest;
    logic [31:0] r_qt;
    logic [31:0] r_x2;
    logic [15:0] r_sec;

    logic [31:0] n_qest;
    logic [31:0] n_rem;

    // estimate is the true quotient or one below it
    assign n_qest = 32'(r_prod >> SH);
    assign n_rem  = r_x2 - r_qt;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_prod <= 64'(i_tick) * 64'(RECIP);
            r_x1   <= i_tick;
            r_qest <= n_qest;
            r_qt   <= 32'(64'(n_qest) * 64'(TPS));
            r_x2   <= r_x1;
            r_sec  <= r_qest[15:0] + 16'(n_rem >= TPS);
        end
    end

    assign o_sec = r_sec;

endmodule

// ===== rtl/core/rssi_proximity_detector.sv =====
// ----------------------------------------------------------------------------
// rssi_proximity_detector: contact tracking from received packet events
// close beacons of the other device type open or extend a contact, weak ones
// close it and may raise a rate limited absent report; sensor packets during
// a long enough contact raise a rate limited detect report
// ----------------------------------------------------------------------------
//
//  channel   direction  handshake                     payload
//  s_axis    in         s_axis_tvalid/s_axis_tready   packet event
//  m_axis    out        m_axis_tvalid/m_axis_tready   detect or absent report
//  cfg       in         i_cfg_valid/o_cfg_ready       register index and data
//
//  one request per cycle sustained while no report waits on m_axis; a report shows
//  on m_axis once its packet has passed the three divider stages (the first loaded
//  at the accept edge) and then the report reg
//  i_rst_n is synchronous and active low; it restores the register defaults
//  and clears the contact state; the cfg channel is always ready
//  a report waiting on m_axis freezes the whole pipeline and drops
//  s_axis_tready; the pipeline moves again in the cycle it is taken
//
module rssi_proximity_detector #(
    parameter int TICKS_PER_SECOND = 65536
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // packet event: peer_device_type, rssi, arrival_tick, source_id, zero fill
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    input  logic [rpd_pkg::IN_DATA_W-1:0]  s_axis_tdata,
    // packet kind: op
    input  logic                           s_axis_tuser,
    // report: event_seconds, peer_id
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    output logic [rpd_pkg::OUT_DATA_W-1:0] m_axis_tdata,
    // report kind: event_kind
    output logic                           m_axis_tuser,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [rpd_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [rpd_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    // seconds thresholds become tick thresholds of this width
    localparam int          TW    = 16 + $clog2(TICKS_PER_SECOND + 1);
    localparam int          CW    = (TW > 32) ? TW : 32;
    localparam logic [TW-1:0] TPS_W = TW'(TICKS_PER_SECOND);

    // configuration registers
    logic signed [7:0] r_rssi_thr;
    logic [15:0]       r_contact_sec;
    logic [15:0]       r_absent_sec;
    logic [15:0]       r_detect_iv;
    logic [15:0]       r_absent_iv;
    logic              r_own_type;

    // tick thresholds, one register after each multiply
    logic [TW-1:0] r_contact_ticks;
    logic [TW-1:0] r_absent_ticks;
    logic [TW-1:0] r_detect_iv_ticks;
    logic [TW-1:0] r_absent_iv_ticks;

    // contact state
    logic        r_in_contact;
    logic [31:0] r_first_tick;
    logic [31:0] r_last_tick;
    logic [15:0] r_first_sec;
    logic [15:0] r_last_sec;
    logic [31:0] r_last_detect;
    logic [31:0] r_last_absent;
    logic        r_detect_seen;

    // pipeline stages alongside the divider
    rpd_pkg::t_event r_s1, r_s2, r_s3;
    logic            r_v1, r_v2, r_v3;

    // report register
    logic        r_out_valid;
    logic        r_out_kind;
    logic [15:0] r_out_sec;
    logic [15:0] r_out_id;

    logic            en;
    rpd_pkg::t_event in_ev;
    logic [15:0]     s3_sec;

    // decision results
    logic        n_in_contact;
    logic [31:0] n_first_tick;
    logic [31:0] n_last_tick;
    logic [15:0] n_first_sec;
    logic [15:0] n_last_sec;
    logic [31:0] n_last_detect;
    logic [31:0] n_last_absent;
    logic        n_detect_seen;
    logic        n_emit;
    logic        n_kind;
    logic [15:0] n_sec;

    logic [31:0] d_since_last;
    logic [31:0] d_since_absent;
    logic [31:0] d_contact_len;
    logic [31:0] d_since_detect;

    // the pipeline moves whenever the report register is free or being taken
    assign en            = !r_out_valid || m_axis_tready;
    assign s_axis_tready = en;
    assign o_cfg_ready   = 1'b1;

    assign in_ev.op        = s_axis_tuser;
    assign in_ev.peer_type = s_axis_tdata[0];
    assign in_ev.rssi      = s_axis_tdata[8:1];
    assign in_ev.tick      = s_axis_tdata[40:9];
    assign in_ev.source_id = s_axis_tdata[56:41];

    rpd_sec_div #(
        .TICKS_PER_SECOND(TICKS_PER_SECOND)
    ) u_sec_div (
        .i_clk (i_clk),
        .i_en  (en),
        .i_tick(in_ev.tick),
        .o_sec (s3_sec)
    );

    // configuration writes; unused indexes are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rssi_thr    <= -8'sd66;
            r_contact_sec <= 16'd15;
            r_absent_sec  <= 16'd30;
            r_detect_iv   <= 16'd15;
            r_absent_iv   <= 16'd30;
            r_own_type    <= 1'b1;
        end else if (i_cfg_valid) begin
            unique case (rpd_pkg::t_cfg_idx'(i_cfg_index))
                rpd_pkg::CFG_RSSI_THRESHOLD:  r_rssi_thr    <= i_cfg_data[7:0];
                rpd_pkg::CFG_CONTACT_SECONDS: r_contact_sec <= i_cfg_data;
                rpd_pkg::CFG_ABSENT_SECONDS:  r_absent_sec  <= i_cfg_data;
                rpd_pkg::CFG_DETECT_INTERVAL: r_detect_iv   <= i_cfg_data;
                rpd_pkg::CFG_ABSENT_INTERVAL: r_absent_iv   <= i_cfg_data;
                rpd_pkg::CFG_OWN_DEVICE_TYPE: r_own_type    <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // seconds to ticks, refreshed every cycle; settles before any packet
    // written after the register reaches the decision stage
    always_ff @(posedge i_clk) begin
        r_contact_ticks   <= TW'(r_contact_sec) * TPS_W;
        r_absent_ticks    <= TW'(r_absent_sec) * TPS_W;
        r_detect_iv_ticks <= TW'(r_detect_iv) * TPS_W;
        r_absent_iv_ticks <= TW'(r_absent_iv) * TPS_W;
    end

    // wrapping tick differences
    assign d_since_last   = r_s3.tick - r_last_tick;
    assign d_since_absent = r_s3.tick - r_last_absent;
    assign d_contact_len  = r_last_tick - r_first_tick;
    assign d_since_detect = r_last_tick - r_last_detect;

    // decision stage: floor(d / tps) >= n is the same as d >= n * tps
    always_comb begin
        n_in_contact  = r_in_contact;
        n_first_tick  = r_first_tick;
        n_last_tick   = r_last_tick;
        n_first_sec   = r_first_sec;
        n_last_sec    = r_last_sec;
        n_last_detect = r_last_detect;
        n_last_absent = r_last_absent;
        n_detect_seen = r_detect_seen;
        n_emit        = 1'b0;
        n_kind        = rpd_pkg::EV_DETECT;
        n_sec         = r_first_sec;
        if (r_s3.op == rpd_pkg::OP_BEACON) begin
            // same-type beacons leave everything alone
            if (r_s3.peer_type != r_own_type) begin
                if (r_s3.rssi >= r_rssi_thr) begin
                    if (!r_in_contact) begin
                        n_in_contact = 1'b1;
                        n_first_tick = r_s3.tick;
                        n_first_sec  = s3_sec;
                    end
                    n_last_tick = r_s3.tick;
                    n_last_sec  = s3_sec;
                end else begin
                    n_in_contact = 1'b0;
                    n_first_tick = r_s3.tick;
                    n_first_sec  = s3_sec;
                    if ((CW'(d_since_last) >= CW'(r_absent_ticks)) &&
                        (CW'(d_since_absent) >= CW'(r_absent_iv_ticks))) begin
                        n_emit        = 1'b1;
                        n_kind        = rpd_pkg::EV_ABSENT;
                        n_sec         = r_last_sec;
                        n_last_absent = r_s3.tick;
                    end
                end
            end
        end else begin
            // first detect skips the interval check
            if (r_in_contact &&
                (CW'(d_contact_len) >= CW'(r_contact_ticks)) &&
                (!r_detect_seen ||
                 (CW'(d_since_detect) >= CW'(r_detect_iv_ticks)))) begin
                n_emit        = 1'b1;
                n_kind        = rpd_pkg::EV_DETECT;
                n_sec         = r_first_sec;
                n_last_detect = r_last_tick;
                n_detect_seen = 1'b1;
            end
        end
    end

    // pipeline valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else if (en) begin
            r_v1 <= s_axis_tvalid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    // pipeline payload
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s1 <= in_ev;
            r_s2 <= r_s1;
            r_s3 <= r_s2;
        end
    end

    // contact state commits when a packet leaves the decision stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_contact  <= 1'b0;
            r_first_tick  <= '0;
            r_last_tick   <= '0;
            r_first_sec   <= '0;
            r_last_sec    <= '0;
            r_last_detect <= '0;
            r_last_absent <= '0;
            r_detect_seen <= 1'b0;
        end else if (en && r_v3) begin
            r_in_contact  <= n_in_contact;
            r_first_tick  <= n_first_tick;
            r_last_tick   <= n_last_tick;
            r_first_sec   <= n_first_sec;
            r_last_sec    <= n_last_sec;
            r_last_detect <= n_last_detect;
            r_last_absent <= n_last_absent;
            r_detect_seen <= n_detect_seen;
        end
    end

    // report register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_out_valid <= r_v3 && n_emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out_kind <= n_kind;
            r_out_sec  <= n_sec;
            r_out_id   <= r_s3.source_id;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = r_out_kind;
    assign m_axis_tdata  = {r_out_id, r_out_sec};

endmodule

// ===== rtl/core/rpd_checker.sv =====
// ----------------------------------------------------------------------------
// rpd_checker: port level checks of the rssi proximity detector
// watches the stream ports and is bound to the top level
// ----------------------------------------------------------------------------
module rpd_checker (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           s_axis_tvalid,
    input logic                           s_axis_tready,
    input logic [rpd_pkg::IN_DATA_W-1:0]  s_axis_tdata,
    input logic                           s_axis_tuser,
    input logic                           m_axis_tvalid,
    input logic                           m_axis_tready,
    input logic [rpd_pkg::OUT_DATA_W-1:0] m_axis_tdata,
    input logic                           m_axis_tuser
);

    // a stalled report holds its payload
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("report changed while stalled");

    // a waiting request holds its payload
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && !s_axis_tready |=>
            s_axis_tvalid && $stable(s_axis_tdata) && $stable(s_axis_tuser))
        else $error("request changed while waiting");

    // with no report pending the input side must be open
    a_ready_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input stalled with empty report register");

    // a new report only appears on a cycle the pipeline was moving
    a_rise_moves: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_axis_tvalid) |-> $past(s_axis_tready))
        else $error("report appeared while pipeline frozen");

    // reset empties the report register
    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("report valid after reset");

endmodule

bind rssi_proximity_detector rpd_checker u_rpd_checker (.*);

// ===== dv/tb_rssi_proximity_detector.sv =====
// ----------------------------------------------------------------------------
// tb_rssi_proximity_detector: self-checking bench of the proximity detector
// drives beacon and sensor requests with random bursts and gaps, stalls the
// report side on shifting patterns, predicts every detect and absent report
// in a small tracker class and compares them field by field in order
// ----------------------------------------------------------------------------
module tb_rssi_proximity_detector;

    timeunit 1ns;
    timeprecision 1ps;

    // device types as carried in a beacon
    localparam logic DEV_SENDER   = 1'b0;
    localparam logic DEV_RECEIVER = 1'b1;

    // register indexes with no register behind them
    localparam logic [rpd_pkg::CFG_IDX_W-1:0] CFG_SPARE_LO = 3'd6;
    localparam logic [rpd_pkg::CFG_IDX_W-1:0] CFG_SPARE_HI = 3'd7;

    localparam int DRAIN_CYCLES   = 40;    // pipeline is four deep, plus receiver stalls
    localparam int WATCHDOG_LIMIT = 2000;  // cycles with no channel moving

    // one expected report
    typedef struct {
        logic        kind;
        logic [15:0] seconds;
        logic [15:0] peer;
    } t_report;

    // tracks contact state and queues the reports the block owes us
    class proximity_tracker;
        logic signed [7:0] threshold;
        logic [15:0]       contact_secs;
        logic [15:0]       absent_secs;
        logic [15:0]       detect_gap;
        logic [15:0]       absent_gap;
        logic              own_type;

        logic              in_contact;
        logic [31:0]       first_tick;
        logic [31:0]       last_tick;
        logic [31:0]       detect_tick;
        logic [31:0]       absent_tick;
        logic              detect_seen;

        t_report           owed_reports[$];
        int                mismatches;
        int                reports_seen;

        function new();
            threshold    = -8'sd66;
            contact_secs = 16'd15;
            absent_secs  = 16'd30;
            detect_gap   = 16'd15;
            absent_gap   = 16'd30;
            own_type     = DEV_RECEIVER;
            in_contact   = 1'b0;
            first_tick   = '0;
            last_tick    = '0;
            detect_tick  = '0;
            absent_tick  = '0;
            detect_seen  = 1'b0;
            mismatches   = 0;
            reports_seen = 0;
        endfunction

        function void set_reg(logic [rpd_pkg::CFG_IDX_W-1:0] idx,
                              logic [rpd_pkg::CFG_DATA_W-1:0] data);
            case (idx)
                rpd_pkg::CFG_RSSI_THRESHOLD:  threshold    = data[7:0];
                rpd_pkg::CFG_CONTACT_SECONDS: contact_secs = data;
                rpd_pkg::CFG_ABSENT_SECONDS:  absent_secs  = data;
                rpd_pkg::CFG_DETECT_INTERVAL: detect_gap   = data;
                rpd_pkg::CFG_ABSENT_INTERVAL: absent_gap   = data;
                rpd_pkg::CFG_OWN_DEVICE_TYPE: own_type     = data[0];
                default: ;
            endcase
        endfunction

        function int pending();
            return owed_reports.size();
        endfunction

        function void note_packet(logic op, logic peer, logic signed [7:0] rssi,
                                  logic [31:0] now, logic [15:0] src);
            logic [31:0] span;
            t_report     rep;
            if (op == rpd_pkg::OP_BEACON) begin
                if (peer == own_type)
                    return;
                if (rssi >= threshold) begin
                    if (!in_contact) begin
                        in_contact = 1'b1;
                        first_tick = now;
                    end
                    last_tick = now;
                    return;
                end
                // weak beacon closes the contact
                in_contact = 1'b0;
                first_tick = now;
                span = now - last_tick;
                if (span >= {absent_secs, 16'h0000}) begin
                    span = now - absent_tick;
                    if (span[31:16] >= absent_gap) begin
                        rep.kind    = rpd_pkg::EV_ABSENT;
                        rep.seconds = last_tick[31:16];
                        rep.peer    = src;
                        owed_reports.push_back(rep);
                        absent_tick = now;
                    end
                end
                return;
            end
            if (!in_contact)
                return;
            span = last_tick - first_tick;
            if (span < {contact_secs, 16'h0000})
                return;
            span = last_tick - detect_tick;
            if (detect_seen && span[31:16] < detect_gap)
                return;
            rep.kind    = rpd_pkg::EV_DETECT;
            rep.seconds = first_tick[31:16];
            rep.peer    = src;
            owed_reports.push_back(rep);
            detect_tick = last_tick;
            detect_seen = 1'b1;
        endfunction

        function void check_report(logic kind, logic [15:0] seconds, logic [15:0] peer);
            t_report want;
            reports_seen++;
            if (owed_reports.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t report %0d not expected: kind %0d seconds %h peer %h",
                             $realtime, reports_seen, kind, seconds, peer);
                return;
            end
            want = owed_reports.pop_front();
            if (want.kind !== kind || want.seconds !== seconds || want.peer !== peer) begin
                mismatches++;
                if (mismatches <= 10)
                    $display({"%0t report %0d: expected kind %0d seconds %h peer %h,",
                              " got %0d %h %h"},
                             $realtime, reports_seen, want.kind, want.seconds, want.peer,
                             kind, seconds, peer);
            end
        endfunction
    endclass

    logic                           i_clk;
    logic                           i_rst_n;
    logic                           s_axis_tvalid;
    logic                           s_axis_tready;
    logic [rpd_pkg::IN_DATA_W-1:0]  s_axis_tdata;
    logic                           s_axis_tuser;
    logic                           m_axis_tvalid;
    logic                           m_axis_tready;
    logic [rpd_pkg::OUT_DATA_W-1:0] m_axis_tdata;
    logic                           m_axis_tuser;
    logic                           i_cfg_valid;
    logic                           o_cfg_ready;
    logic [rpd_pkg::CFG_IDX_W-1:0]  i_cfg_index;
    logic [rpd_pkg::CFG_DATA_W-1:0] i_cfg_data;

    proximity_tracker tracker = new();

    int burst_left;    // requests left in the current sender burst
    int cur_thr;       // threshold now programmed, steers rssi around it
    int idle_count;    // watchdog: cycles with nothing accepted
    int ready_cycle;
    int ready_mode;
    logic [15:0] stall_pat;

    rssi_proximity_detector u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    // 2 ns clock, low first so the first rising edge comes after setup
    always begin
        i_clk = 1'b0;
        #1;
        i_clk = 1'b1;
        #1;
    end

    // receiver: always ready, random, or a rotating pattern that is never all stall
    always @(posedge i_clk) begin
        if (ready_cycle % 128 == 0) begin
            ready_mode = $urandom_range(0, 2);
            stall_pat  = 16'($urandom) | 16'h0001;
        end
        ready_cycle++;
        case (ready_mode)
            0: m_axis_tready <= 1'b1;
            1: m_axis_tready <= ($urandom_range(0, 3) != 0);
            default: begin
                m_axis_tready <= stall_pat[0];
                stall_pat = {stall_pat[0], stall_pat[15:1]};
            end
        endcase
    end

    // every accepted report goes to the tracker; values sampled before the edge
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready)
            tracker.check_report(m_axis_tuser, m_axis_tdata[15:0], m_axis_tdata[31:16]);
    end

    // watchdog: the run is stuck if no channel moves for too long
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
            (i_cfg_valid && o_cfg_ready))
            idle_count = 0;
        else
            idle_count++;
        if (idle_count >= WATCHDOG_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // drop tvalid and hold the sender idle; n sets how long
    task automatic idle(int n);
        s_axis_tvalid <= 1'b0;
        repeat (n) @(posedge i_clk);
    endtask

    // one packet request; gaps between bursts are inserted here
    task automatic send_packet(logic op, logic peer, logic [7:0] rssi,
                               logic [31:0] tick, logic [15:0] src);
        int gap;
        if (burst_left == 0) begin
            gap = $urandom_range(0, 7);
            if (gap != 0)
                idle(gap);
            burst_left = $urandom_range(1, 24);
        end
        burst_left--;
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        // tdata: peer_device_type, rssi, arrival_tick, source_id, zero fill
        s_axis_tdata  <= {7'd0, src, tick, rssi, peer};
        do @(posedge i_clk); while (!s_axis_tready);
        tracker.note_packet(op, peer, rssi, tick, src);
    endtask

    // hold the sender until every owed report is out and the pipeline is empty
    task automatic wait_drain();
        idle(1);
        while (tracker.pending() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic cfg_write(logic [rpd_pkg::CFG_IDX_W-1:0] idx,
                             logic [rpd_pkg::CFG_DATA_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        tracker.set_reg(idx, data);
    endtask

    // program all registers while idle; upper data bits are noise the block must mask
    task automatic apply_settings(int thr, int contact, int absent, int det_gap,
                                  int abs_gap, logic own);
        wait_drain();
        cfg_write(rpd_pkg::CFG_RSSI_THRESHOLD, {8'($urandom), 8'(thr)});
        cfg_write(rpd_pkg::CFG_CONTACT_SECONDS, 16'(contact));
        cfg_write(rpd_pkg::CFG_ABSENT_SECONDS, 16'(absent));
        cfg_write(rpd_pkg::CFG_DETECT_INTERVAL, 16'(det_gap));
        cfg_write(rpd_pkg::CFG_ABSENT_INTERVAL, 16'(abs_gap));
        cfg_write(rpd_pkg::CFG_OWN_DEVICE_TYPE, {15'($urandom), own});
        // writes to spare indexes must change nothing
        cfg_write($urandom_range(0, 1) ? CFG_SPARE_HI : CFG_SPARE_LO, 16'($urandom));
        i_cfg_valid <= 1'b0;
        cur_thr = thr;
    endtask

    function automatic logic [7:0] clip_rssi(int v);
        if (v > 127)
            return 8'd127;
        if (v < -128)
            return 8'h80;
        return 8'(v);
    endfunction

    // mostly contact sequences: runs of close beacons, sensors, weak beacons
    task automatic run_random_phase(int n_items, int step_max, logic [31:0] start_tick);
        int          i;
        int          kind;
        int          pause_at;
        logic        close_run;
        logic        own;
        logic [31:0] tick;
        tick      = start_tick;
        close_run = 1'b1;
        pause_at  = $urandom_range(5, n_items - 5);
        for (i = 0; i < n_items; i++) begin
            if (i == pause_at)
                wait_drain();
            if ($urandom_range(0, 9) == 0)
                close_run = ~close_run;
            tick = tick + ($urandom_range(0, step_max) << 16) + $urandom_range(0, 65535);
            if ($urandom_range(0, 49) == 0)
                tick = tick + $urandom;
            own  = tracker.own_type;
            kind = $urandom_range(0, 99);
            if (kind < 50)
                send_packet(rpd_pkg::OP_BEACON, ~own,
                            close_run ? clip_rssi(cur_thr + $urandom_range(0, 8))
                                      : clip_rssi(cur_thr - 1 - $urandom_range(0, 8)),
                            tick, 16'($urandom));
            else if (kind < 60)
                send_packet(rpd_pkg::OP_BEACON, own, 8'($urandom), tick, 16'($urandom));
            else if (kind < 92)
                send_packet(rpd_pkg::OP_SENSOR, 1'($urandom), 8'($urandom), tick,
                            16'($urandom));
            else
                send_packet(1'($urandom), 1'($urandom), 8'($urandom), $urandom,
                            16'($urandom));
        end
    endtask

    initial begin
        int ph;
        i_rst_n       <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= 1'b0;
        m_axis_tready <= 1'b0;
        i_cfg_valid   <= 1'b0;
        i_cfg_index   <= '0;
        i_cfg_data    <= '0;
        burst_left  = 0;
        cur_thr     = -66;
        idle_count  = 0;
        ready_cycle = 0;
        ready_mode  = 0;
        stall_pat   = 16'hffff;

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed, reset settings: threshold -66, contact 15 s, absent 30 s
        send_packet(rpd_pkg::OP_BEACON, DEV_RECEIVER, 8'sd127, 32'd0, 16'h0001);  // same type
        send_packet(rpd_pkg::OP_SENSOR, DEV_SENDER, 8'h00, 32'd5, 16'h0002);      // no contact
        send_packet(rpd_pkg::OP_BEACON, DEV_SENDER, -8'sd66, 32'd1 << 16,
                    16'h0003);                                                    // at threshold
        send_packet(rpd_pkg::OP_SENSOR, DEV_SENDER, 8'h00, 32'd2 << 16, 16'h0004); // too short
        send_packet(rpd_pkg::OP_BEACON, DEV_SENDER, 8'sd127, 32'd20 << 16, 16'h0005);
        send_packet(rpd_pkg::OP_SENSOR, DEV_SENDER, 8'h00, 32'd21 << 16,
                    16'h0006);                                                    // first detect
        send_packet(rpd_pkg::OP_SENSOR, DEV_RECEIVER, 8'hff, 32'd22 << 16,
                    16'h0007);                                                    // rate limited
        send_packet(rpd_pkg::OP_BEACON, DEV_SENDER, -8'sd67, 32'd25 << 16,
                    16'h0008);                                                    // ends contact
        send_packet(rpd_pkg::OP_BEACON, DEV_SENDER, -8'sd128, 32'd60 << 16,
                    16'h0009);                                                    // first absent
        send_packet(rpd_pkg::OP_BEACON, DEV_SENDER, -8'sd100, 32'd70 << 16,
                    16'h000a);                                                    // absent limited
        send_packet(rpd_pkg::OP_SENSOR, DEV_SENDER, 8'h7f, 32'd71 << 16, 16'h000b);
        send_packet(rpd_pkg::OP_BEACON, DEV_SENDER, 8'h00, 32'hffff_ffff,
                    16'h5555);                                                    // near wrap
        send_packet(rpd_pkg::OP_BEACON, DEV_SENDER, 8'h00, 32'h000f_0000,
                    16'haaaa);                                                    // tick wraps
        send_packet(rpd_pkg::OP_SENSOR, DEV_SENDER, 8'h80, 32'h000f_0001,
                    16'hffff);                                                    // seconds 0xffff
        send_packet(rpd_pkg::OP_SENSOR, DEV_SENDER, 8'h80, 32'h000f_0002, 16'h0000);
        send_packet(rpd_pkg::OP_BEACON, DEV_SENDER, -8'sd128, 32'h0020_0000, 16'h1234);
        send_packet(rpd_pkg::OP_BEACON, DEV_RECEIVER, -8'sd128, 32'h7fff_ffff, 16'h4321);
        send_packet(rpd_pkg::OP_BEACON, DEV_SENDER, -8'sd128, 32'hffff_fffe, 16'h8001);

        // low extremes: everything close, no waiting anywhere
        apply_settings(-128, 0, 0, 0, 0, DEV_SENDER);
        run_random_phase(70, 3, $urandom);

        // high extremes: only the strongest beacon counts, huge thresholds
        apply_settings(127, 65535, 65535, 65535, 65535, DEV_RECEIVER);
        run_random_phase(60, 30000, 32'hfff0_0000);

        // moderate random settings where reports come often
        for (ph = 0; ph < 7; ph++) begin
            apply_settings(-40 - int'($urandom_range(0, 60)), $urandom_range(0, 12),
                           $urandom_range(0, 20), $urandom_range(0, 12),
                           $urandom_range(0, 20), 1'($urandom));
            run_random_phase(85, 4, (ph == 3) ? 32'hffc0_0000 : $urandom);
        end

        wait_drain();
        if (tracker.mismatches == 0 && tracker.pending() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/core/rpd_pkg.sv
rtl/core/rpd_sec_div.sv
rtl/core/rssi_proximity_detector.sv
rtl/core/rpd_checker.sv
dv/tb_rssi_proximity_detector.sv
